>>> design/brrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brrb_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 64;
    localparam int unsigned BLOCK_COUNT_DEF = 4;

    localparam logic [31:0] AHEAD_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic {
        OP_RX   = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EXEC,
        S_AVAIL,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic check;
        logic exec;
        logic avail;
        logic load;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> design/brrb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface brrb_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface brrb_out_if #(
    parameter int unsigned AVAIL_W = 9
);
    logic               valid;
    logic               ready;
    logic               data_valid;
    logic [7:0]         read_data;
    logic [AVAIL_W-1:0] bytes_available;
    logic               block_dropped;

    modport source (
        output valid, output data_valid, output read_data,
        output bytes_available, output block_dropped, input ready
    );
    modport sink (
        input valid, input data_valid, input read_data,
        input bytes_available, input block_dropped, output ready
    );
endinterface

`default_nettype wire

>>> design/brrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module brrb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    output brrb_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);

    brrb_pkg::t_state r_state;
    brrb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            brrb_pkg::S_IDLE: begin
                if (i_in_valid) n_state = brrb_pkg::S_CHECK;
            end
            brrb_pkg::S_CHECK: n_state = brrb_pkg::S_EXEC;
            brrb_pkg::S_EXEC:  n_state = brrb_pkg::S_AVAIL;
            brrb_pkg::S_AVAIL: n_state = brrb_pkg::S_LOAD;
            brrb_pkg::S_LOAD:  n_state = brrb_pkg::S_OUT;
            brrb_pkg::S_OUT: begin
                if (i_out_ready) n_state = brrb_pkg::S_IDLE;
            end
            default: n_state = brrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            brrb_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            brrb_pkg::S_CHECK: o_cmd.check = 1'b1;
            brrb_pkg::S_EXEC:  o_cmd.exec  = 1'b1;
            brrb_pkg::S_AVAIL: o_cmd.avail = 1'b1;
            brrb_pkg::S_LOAD:  o_cmd.load  = 1'b1;
            brrb_pkg::S_OUT:   o_out_valid = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("result not presented after load");

endmodule

`default_nettype wire

>>> design/brrb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module brrb_dp #(
    parameter int unsigned BLOCK_BYTES = brrb_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned BLOCK_COUNT = brrb_pkg::BLOCK_COUNT_DEF,
    parameter int unsigned AVAIL_W     = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire brrb_pkg::t_dp_cmd  i_cmd,
    input  wire logic               i_opcode,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_data_valid,
    output logic [7:0]              o_read_data,
    output logic [AVAIL_W-1:0]      o_bytes_available,
    output logic                    o_block_dropped
);

    localparam int unsigned RING_BYTES = BLOCK_BYTES * BLOCK_COUNT;
    localparam int unsigned OFF_W      = $clog2(BLOCK_BYTES);
    localparam int unsigned BLK_W      = $clog2(BLOCK_COUNT);
    localparam int unsigned SLOT_W     = $clog2(RING_BYTES);
    localparam logic [31:0] RING32     = 32'(RING_BYTES);
    localparam logic [31:0] BB32       = 32'(BLOCK_BYTES);

    logic [7:0]        r_mem [RING_BYTES];

    brrb_pkg::t_op     r_op;
    logic [7:0]        r_byte;
    logic [31:0]       r_rd_cnt;
    logic [31:0]       r_wr_cnt;
    logic [BLK_W-1:0]  r_fill_blk;
    logic [OFF_W-1:0]  r_fill_off;
    logic [SLOT_W-1:0] r_wr_slot;
    logic [BLK_W-1:0]  r_rd_blk;
    logic [OFF_W-1:0]  r_rd_off;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [31:0]       r_diff_w;
    logic [31:0]       r_diff_a;
    logic [7:0]        r_mem_q;
    logic              r_valid;
    logic [7:0]        r_data;
    logic              r_drop;

    logic              fill_last;
    logic [BLK_W-1:0]  n_fill_blk;
    logic              push;
    logic [SLOT_W-1:0] rd_base;
    logic [SLOT_W-1:0] rd_next_blk_slot;
    logic [BLK_W-1:0]  rd_blk_inc;
    logic              rd_last;
    logic              rd_ok;
    logic [31:0]       diff_now;
    logic [31:0]       sat_avail;

    assign fill_last  = (r_fill_off == OFF_W'(BLOCK_BYTES - 1));
    assign n_fill_blk = (r_fill_blk == BLK_W'(BLOCK_COUNT - 1)) ? '0 : r_fill_blk + 1'b1;
    assign push       = fill_last && (r_rd_blk == n_fill_blk);
    assign rd_blk_inc = (r_rd_blk == BLK_W'(BLOCK_COUNT - 1)) ? '0 : r_rd_blk + 1'b1;
    assign rd_base    = r_rd_slot - SLOT_W'(r_rd_off);
    assign rd_next_blk_slot = (rd_base == SLOT_W'(RING_BYTES - BLOCK_BYTES)) ? '0
                            : rd_base + SLOT_W'(BLOCK_BYTES);
    assign rd_last    = (r_rd_off == OFF_W'(BLOCK_BYTES - 1));
    assign rd_ok      = ((r_diff_w != '0) && (r_diff_w < brrb_pkg::AHEAD_LIMIT))
                     || ((r_diff_a != '0) && (r_diff_a <= brrb_pkg::AHEAD_LIMIT));
    assign diff_now   = r_wr_cnt + 32'(r_fill_off) - r_rd_cnt;
    assign sat_avail  = (r_diff_a > brrb_pkg::AHEAD_LIMIT) ? '0
                      : (r_diff_a > RING32) ? RING32 : r_diff_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == brrb_pkg::OP_RX)) begin
            r_mem[r_wr_slot] <= r_byte;
        end
        if (i_cmd.check) begin
            r_mem_q <= r_mem[r_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= brrb_pkg::t_op'(i_opcode);
            r_byte <= i_rx_byte;
        end
        if (i_cmd.check) begin
            r_diff_w <= r_wr_cnt - r_rd_cnt;
            r_diff_a <= diff_now;
        end
        if (i_cmd.avail) begin
            r_diff_a <= diff_now;
        end
        if (i_cmd.load) begin
            o_data_valid      <= r_valid;
            o_read_data       <= r_data;
            o_bytes_available <= AVAIL_W'(sat_avail);
            o_block_dropped   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt   <= '0;
            r_wr_cnt   <= '0;
            r_fill_blk <= '0;
            r_fill_off <= '0;
            r_wr_slot  <= '0;
            r_rd_blk   <= '0;
            r_rd_off   <= '0;
            r_rd_slot  <= '0;
            r_valid    <= 1'b0;
            r_data     <= '0;
            r_drop     <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_op == brrb_pkg::OP_RX) begin
                r_valid   <= 1'b0;
                r_data    <= '0;
                r_drop    <= push;
                r_wr_slot <= (r_wr_slot == SLOT_W'(RING_BYTES - 1)) ? '0
                           : r_wr_slot + 1'b1;
                if (fill_last) begin
                    r_fill_off <= '0;
                    r_fill_blk <= n_fill_blk;
                    r_wr_cnt   <= r_wr_cnt + BB32;
                    if (push) begin
                        r_rd_cnt  <= r_rd_cnt - 32'(r_rd_off) + BB32;
                        r_rd_off  <= '0;
                        r_rd_blk  <= rd_blk_inc;
                        r_rd_slot <= rd_next_blk_slot;
                    end
                end else begin
                    r_fill_off <= r_fill_off + 1'b1;
                end
            end else begin
                r_drop <= 1'b0;
                if (rd_ok) begin
                    r_valid   <= 1'b1;
                    r_data    <= r_mem_q;
                    r_rd_cnt  <= r_rd_cnt + 32'd1;
                    r_rd_slot <= (r_rd_slot == SLOT_W'(RING_BYTES - 1)) ? '0
                               : r_rd_slot + 1'b1;
                    if (rd_last) begin
                        r_rd_off <= '0;
                        r_rd_blk <= rd_blk_inc;
                    end else begin
                        r_rd_off <= r_rd_off + 1'b1;
                    end
                end else begin
                    r_valid <= 1'b0;
                    r_data  <= '0;
                end
            end
        end
    end

    a_read_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == brrb_pkg::OP_READ) && rd_ok)
        |=> (r_rd_cnt == $past(r_rd_cnt) + 32'd1))
        else $error("read count did not advance on a served read");

    a_block_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == brrb_pkg::OP_RX) && fill_last)
        |=> ((r_fill_off == '0) && (r_wr_cnt == $past(r_wr_cnt) + BB32)))
        else $error("block completion not recorded");

    a_drop_only_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !(o_block_dropped && o_data_valid))
        else $error("drop flagged on a read result");

endmodule

`default_nettype wire

>>> design/block_ring_rx_buffer.sv
// Receive byte ring of BLOCK_COUNT blocks of BLOCK_BYTES each. A transfer with
// opcode 0 stores rx_byte; completing a block may push the reader to the next
// block and raise block_dropped. Opcode 1 reads the next byte if one is
// available. Every transfer yields one result carrying bytes_available,
// saturated at the ring size. One item is handled at a time: a sequencer walks
// memory read, pointer update, count difference and saturation in the states
// CHECK, EXEC, AVAIL and LOAD, then presents the result in OUT, and the block
// takes no new item until that result has been transferred.
// The ring memory is not cleared at reset; bytes_available is as wide as
// needed to hold the ring size.
`timescale 1ns / 1ps
`default_nettype none

module block_ring_rx_buffer #(
    parameter int unsigned BLOCK_BYTES = brrb_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned BLOCK_COUNT = brrb_pkg::BLOCK_COUNT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    brrb_in_if.sink     i_in,
    brrb_out_if.source  o_out
);

    localparam int unsigned AVAIL_W = $clog2(BLOCK_BYTES * BLOCK_COUNT + 1);

    brrb_pkg::t_dp_cmd cmd;
    logic              in_ready;
    logic              out_valid;
    logic              data_valid;
    logic [7:0]        read_data;
    logic [AVAIL_W-1:0] bytes_available;
    logic              block_dropped;

    brrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    brrb_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT),
        .AVAIL_W     (AVAIL_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_opcode          (i_in.opcode),
        .i_rx_byte         (i_in.rx_byte),
        .o_data_valid      (data_valid),
        .o_read_data       (read_data),
        .o_bytes_available (bytes_available),
        .o_block_dropped   (block_dropped)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.data_valid      = data_valid;
    assign o_out.read_data       = read_data;
    assign o_out.bytes_available = bytes_available;
    assign o_out.block_dropped   = block_dropped;

endmodule

`default_nettype wire
